@@ rtl/core/pdre_pkg.sv @@
// Shared types and constants for the pixel delta run-length encoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package pdre_pkg;

	// Width of the run counter.
	localparam int RUN_BITS = 25;
	// Bits needed to name one bit position of the run counter.
	localparam int RUN_IDX_W = $clog2(RUN_BITS);
	// The run counter stops growing at this count.
	localparam logic [RUN_BITS-1:0] RUN_CAP = RUN_BITS'((64'd1 << RUN_BITS) - 64'd32);

	// A run of at most this many pixels fits in one word.
	localparam logic [RUN_BITS-1:0] SHORT_RUN_MAX = RUN_BITS'(224);
	// Top byte of a power-of-two word is this base plus the exponent minus this offset.
	localparam logic [7:0] LONG_CODE_BASE = 8'hE0;
	localparam logic [7:0] LONG_CODE_OFFSET = 8'd7;

	// Depth of the job queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	// One finished run waiting to be turned into words.
	typedef struct packed {
		logic [23:0] delta;
		logic [RUN_BITS-1:0] run;
		logic last;
	} flush_job_t;

endpackage
`default_nettype wire

@@ rtl/core/pdre_front.sv @@
// Front end: forms the pixel delta, tracks the open run and posts flush jobs.
// Depends on pdre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdre_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [31:0] new_pixel,
	input wire logic [31:0] old_pixel,
	input wire logic end_of_rect,
	input wire logic q_full,
	output logic push_valid,
	output pdre_pkg::flush_job_t push_job
);

	logic [pdre_pkg::RUN_BITS-1:0] run_q;
	logic [23:0] prev_q;
	logic pend_q;
	pdre_pkg::flush_job_t pend_job_q;

	logic [23:0] delta;
	logic same;
	logic accept;
	logic [pdre_pkg::RUN_BITS-1:0] run_inc;
	logic [pdre_pkg::RUN_BITS-1:0] new_run;
	pdre_pkg::flush_job_t change_job;
	pdre_pkg::flush_job_t end_job;

	// Bytewise delta of red, green and blue; alpha is dropped.
	assign delta = {new_pixel[23:16] - old_pixel[23:16],
			new_pixel[15:8] - old_pixel[15:8],
			new_pixel[7:0] - old_pixel[7:0]};

	// An empty run or an equal delta extends the run.
	assign same = (run_q == '0) || (delta == prev_q);
	assign run_inc = (run_q < pdre_pkg::RUN_CAP) ? run_q + 1'b1 : run_q;
	assign new_run = same ? run_inc : pdre_pkg::RUN_BITS'(1);

	assign change_job = '{delta: prev_q, run: run_q, last: 1'b0};
	assign end_job = '{delta: delta, run: new_run, last: 1'b1};

	// A second job from the same word blocks new words until it is queued.
	assign in_ready = !pend_q && !q_full;
	assign accept = in_valid && in_ready;

	// Queue write: the held job first, else the job of the word just taken.
	always_comb begin
		push_valid = 1'b0;
		push_job = end_job;
		if (pend_q) begin
			push_valid = !q_full;
			push_job = pend_job_q;
		end else if (accept) begin
			if (!same) begin
				push_valid = 1'b1;
				push_job = change_job;
			end else if (end_of_rect) begin
				push_valid = 1'b1;
				push_job = end_job;
			end
		end
	end

	// Run state and the held second job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			prev_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && !q_full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (end_of_rect) begin
					run_q <= '0;
					prev_q <= '0;
					if (!same) begin
						pend_q <= 1'b1;
					end
				end else begin
					run_q <= new_run;
					prev_q <= delta;
				end
			end
		end
	end

	// Payload of the held job needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_job_q <= end_job;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/pdre_queue.sv @@
// Small job queue that decouples the front end from the word generator.
// Depends on pdre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdre_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	input wire pdre_pkg::flush_job_t push_job,
	output logic full,
	input wire logic pop,
	output logic head_valid,
	output pdre_pkg::flush_job_t head_job
);

	pdre_pkg::flush_job_t mem_q [pdre_pkg::QUEUE_DEPTH];
	logic [pdre_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [pdre_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [pdre_pkg::QUEUE_AW:0] count_q;

	assign full = (count_q == (pdre_pkg::QUEUE_AW+1)'(pdre_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/pdre_back.sv @@
// Back end: splits each queued run into code words, one word per cycle while the output is not stalled.
// Depends on pdre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdre_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic head_valid,
	input wire pdre_pkg::flush_job_t head_job,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] code_word,
	output logic last_word
);

	logic busy_q;
	pdre_pkg::flush_job_t work_q;
	logic out_valid_q;
	logic [31:0] code_q;
	logic last_q;

	pdre_pkg::flush_job_t src;
	logic src_valid;
	logic emit;
	logic short_run;
	logic done;
	logic [pdre_pkg::RUN_IDX_W-1:0] top;
	logic [pdre_pkg::RUN_BITS-1:0] top_mask;
	logic [pdre_pkg::RUN_BITS-1:0] rem;
	logic [pdre_pkg::RUN_BITS-1:0] run_m1;
	logic [7:0] code_byte;

	// A run in progress takes priority over the queue head.
	assign src = busy_q ? work_q : head_job;
	assign src_valid = busy_q || head_valid;
	assign emit = src_valid && (!out_valid_q || out_ready);
	assign pop = emit && !busy_q;

	// Highest set bit of the remaining run.
	always_comb begin
		top = '0;
		for (int i = 0; i < pdre_pkg::RUN_BITS; i++) begin
			if (src.run[i]) begin
				top = pdre_pkg::RUN_IDX_W'(i);
			end
		end
	end

	// Word code: run minus one for a short run, else the peeled exponent.
	always_comb begin
		top_mask = pdre_pkg::RUN_BITS'(1) << top;
		rem = src.run & ~top_mask;
		run_m1 = src.run - pdre_pkg::RUN_BITS'(1);
		short_run = (src.run <= pdre_pkg::SHORT_RUN_MAX);
		done = short_run || (rem == '0);
		if (short_run) begin
			code_byte = run_m1[7:0];
		end else begin
			code_byte = pdre_pkg::LONG_CODE_BASE + 8'(top) - pdre_pkg::LONG_CODE_OFFSET;
		end
	end

	// Control: run in progress and output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				busy_q <= !done;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: remaining run and the output word.
	always_ff @(posedge clk) begin
		if (emit) begin
			work_q <= '{delta: src.delta, run: rem, last: src.last};
			code_q <= {code_byte, src.delta};
			last_q <= src.last && done;
		end
	end

	assign out_valid = out_valid_q;
	assign code_word = code_q;
	assign last_word = last_q;

endmodule
`default_nettype wire

@@ rtl/core/pixel_delta_run_length_encoder.sv @@
// Pixel delta run-length encoder, top level.
// Input channel: new_pixel, old_pixel and end_of_rect under in_valid/in_ready.
// Output channel: code_word and last_word under out_valid/out_ready.
// A word is accepted on any edge where its channel's valid and ready are high.
// The front end takes one pixel per cycle while the queue has room; a pixel that
// both ends a run and ends a rectangle needs two queue slots and holds in_ready
// low until its second job is queued. A flush job passes through the queue and
// its words through the output register. The word generator makes one code word
// per cycle while the receiver does not stall: one for a run of up to 224 pixels,
// and up to RUN_BITS - 7 for the longest run, one for each power of two peeled
// off and one for the short remainder. A four-entry job queue sits between them.
// When the receiver stalls, the output register holds its word, the queue fills,
// and in_ready falls once the queue is full. Reset clears the open run, the
// queue and the output register; the block is ready for words once reset ends.
// Depends on pdre_pkg, pdre_front, pdre_queue and pdre_back.
`timescale 1ns / 1ps
`default_nettype none
module pixel_delta_run_length_encoder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [31:0] new_pixel,
	input wire logic [31:0] old_pixel,
	input wire logic end_of_rect,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] code_word,
	output logic last_word
);

	logic q_full;
	logic q_push;
	pdre_pkg::flush_job_t q_push_job;
	logic q_pop;
	logic q_head_valid;
	pdre_pkg::flush_job_t q_head_job;

	// Pixel intake and run tracking.
	pdre_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.new_pixel(new_pixel),
		.old_pixel(old_pixel),
		.end_of_rect(end_of_rect),
		.q_full(q_full),
		.push_valid(q_push),
		.push_job(q_push_job)
	);

	// Flush jobs waiting for the word generator.
	pdre_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(q_push),
		.push_job(q_push_job),
		.full(q_full),
		.pop(q_pop),
		.head_valid(q_head_valid),
		.head_job(q_head_job)
	);

	// Code word generation.
	pdre_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(q_head_valid),
		.head_job(q_head_job),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_word(code_word),
		.last_word(last_word)
	);

	// The front end never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into a full queue");

	// The back end only pops a queue that holds a job.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("job popped from an empty queue");

	// Top byte is a short-run count or an exponent code within the counter width.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (code_word[31:24] <=
			8'(pdre_pkg::LONG_CODE_BASE + 8'(pdre_pkg::RUN_BITS - 1)
			- pdre_pkg::LONG_CODE_OFFSET)))
		else $error("code word top byte out of range");

endmodule
`default_nettype wire

@@ tb/sv/tb_pixel_delta_run_length_encoder.sv @@
// Self-checking testbench for the pixel delta run-length encoder.
// Predicts every code word from the accepted pixels and checks each output word in order.
// Depends on pdre_pkg and pixel_delta_run_length_encoder.
`timescale 1ns / 1ps
module tb_pixel_delta_run_length_encoder;

	// One expected code word.
	typedef struct {
		logic [31:0] code;
		logic last;
	} coded_word_t;

	// Tracks the open run, predicts the words it flushes and checks them.
	class delta_run_tracker;
		logic [pdre_pkg::RUN_BITS-1:0] run_length;
		logic [23:0] run_delta;
		coded_word_t pending_words[$];
		int mismatch_count;

		function new();
			run_length = '0;
			run_delta = '0;
			mismatch_count = 0;
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		task report_mismatch(input string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			mismatch_count++;
		endtask

		function int top_bit(input logic [pdre_pkg::RUN_BITS-1:0] v);
			int m;
			m = 0;
			for (int i = 0; i < pdre_pkg::RUN_BITS; i++)
				if (v[i])
					m = i;
			return m;
		endfunction

		// Splits one run into words: powers of two first, then the short remainder.
		function void push_run(input logic [23:0] d,
				input logic [pdre_pkg::RUN_BITS-1:0] run);
			coded_word_t w;
			logic [pdre_pkg::RUN_BITS-1:0] left;
			int m;
			left = run;
			while (left != '0) begin
				w.last = 1'b0;
				if (left <= pdre_pkg::SHORT_RUN_MAX) begin
					w.code = {8'(left - 1'b1), d};
					pending_words.push_back(w);
					left = '0;
				end else begin
					m = top_bit(left);
					w.code = {8'(pdre_pkg::LONG_CODE_BASE + 8'(m)
						- pdre_pkg::LONG_CODE_OFFSET), d};
					pending_words.push_back(w);
					left = left - (pdre_pkg::RUN_BITS'(1) << m);
				end
			end
		endfunction

		// Called for every accepted pixel word.
		function void note_pixel(input logic [31:0] np, input logic [31:0] op, input logic eor);
			logic [23:0] d;
			int prior_count;
			d[23:16] = np[23:16] - op[23:16];
			d[15:8] = np[15:8] - op[15:8];
			d[7:0] = np[7:0] - op[7:0];
			prior_count = pending_words.size();
			// An empty run takes any delta; a changed delta closes the open run.
			if (run_length == '0 || d == run_delta) begin
				if (run_length < pdre_pkg::RUN_CAP)
					run_length = run_length + 1'b1;
			end else begin
				push_run(run_delta, run_length);
				run_length = pdre_pkg::RUN_BITS'(1);
			end
			run_delta = d;
			// The end of a rectangle flushes the open run and marks its final word.
			if (eor) begin
				push_run(run_delta, run_length);
				if (pending_words.size() > prior_count)
					pending_words[pending_words.size() - 1].last = 1'b1;
				run_length = '0;
				run_delta = '0;
			end
		endfunction

		// Called for every accepted output word.
		task check_word(input logic [31:0] code, input logic last);
			coded_word_t w;
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h last %b", code, last));
			end else begin
				w = pending_words.pop_front();
				if (code !== w.code)
					report_mismatch($sformatf("code_word %h, predicted %h", code, w.code));
				if (last !== w.last)
					report_mismatch($sformatf("last_word %b, predicted %b", last, w.last));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [31:0] new_pixel;
	logic [31:0] old_pixel;
	logic end_of_rect;
	logic out_valid;
	logic out_ready;
	logic [31:0] code_word;
	logic last_word;

	delta_run_tracker tracker = new();
	bit idle_on;
	logic [23:0] last_delta;

	pixel_delta_run_length_encoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.new_pixel(new_pixel),
		.old_pixel(old_pixel),
		.end_of_rect(end_of_rect),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_word(code_word),
		.last_word(last_word)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: checks accepted words and stalls in random bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_word(code_word, last_word);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offers one pixel word, after an optional idle burst, and waits for it to be taken.
	task automatic send_pixel(input logic [31:0] np, input logic [31:0] op, input logic eor);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		new_pixel <= np;
		old_pixel <= op;
		end_of_rect <= eor;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.note_pixel(np, op, eor);
	endtask

	// Builds a random pixel pair whose color difference is d.
	task automatic send_delta(input logic [23:0] d, input logic eor);
		logic [31:0] op;
		logic [31:0] np;
		op = $urandom;
		np[31:24] = 8'($urandom_range(0, 255));
		np[23:16] = op[23:16] + d[23:16];
		np[15:8] = op[15:8] + d[15:8];
		np[7:0] = op[7:0] + d[7:0];
		send_pixel(np, op, eor);
	endtask

	task automatic send_run(input logic [23:0] d, input int len, input logic eor);
		for (int i = 0; i < len; i++)
			send_delta(d, eor && i == len - 1);
	endtask

	// Holds the sender until every predicted word has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Random runs of equal deltas, mixed with lone random pixels and stray rectangle ends.
	task automatic random_runs(input int n_items);
		int sent;
		int len;
		logic [23:0] d;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 4) == 0) begin
				send_pixel($urandom, $urandom, $urandom_range(0, 5) == 0);
				sent++;
			end else begin
				case ($urandom_range(0, 5))
					0: d = 24'h000000;
					1: d = 24'hFFFFFF;
					2: d = last_delta;
					default: d = 24'($urandom);
				endcase
				last_delta = d;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
				for (int i = 0; i < len; i++) begin
					send_delta(d, (i == len - 1 && $urandom_range(0, 4) == 0) ||
						$urandom_range(0, 30) == 0);
					sent++;
				end
			end
		end
	endtask

	// Main stimulus.
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		new_pixel <= '0;
		old_pixel <= '0;
		end_of_rect <= 1'b0;
		idle_on = 1'b1;
		last_delta = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: an empty run starting on a zero delta, ignored top bytes, byte
		// wraparound, change and end together, and one-pixel rectangles.
		send_pixel(32'h00000000, 32'h00000000, 1'b0);
		send_pixel(32'hAB123456, 32'hCD123456, 1'b0);
		send_pixel(32'hFFFFFFFF, 32'h00000000, 1'b0);
		send_pixel(32'h00000000, 32'hFF010101, 1'b0);
		send_pixel(32'h80808080, 32'h7F7F7F7F, 1'b1);
		send_pixel(32'h00FFFFFF, 32'hFFFFFFFF, 1'b1);
		send_run(24'h00FF00, 4, 1'b1);
		send_delta(24'h000001, 1'b0);
		send_run(24'h800000, 2, 1'b1);
		send_delta(24'h5A5A5A, 1'b0);
		send_delta(24'hA5A5A5, 1'b1);
		wait_drained();

		// A run just past the one-word limit splits into a power of two and a remainder.
		send_run(24'h222222, 225, 1'b1);
		wait_drained();

		random_runs(50);
		wait_drained();

		// Final stretch at full rate on both sides.
		idle_on = 1'b0;
		random_runs(25);
		send_delta(24'($urandom), 1'b1);
		in_valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ pixel_delta_run_length_encoder.f @@
rtl/core/pdre_pkg.sv
rtl/core/pdre_front.sv
rtl/core/pdre_queue.sv
rtl/core/pdre_back.sv
rtl/core/pixel_delta_run_length_encoder.sv
tb/sv/tb_pixel_delta_run_length_encoder.sv
